/* hdl/rie_pkg.sv */
// Shared types and constants of the instruction execute unit.
package rie_pkg;

	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SUB  = 5'd1;
	localparam logic [4:0] OP_MUL  = 5'd2;
	localparam logic [4:0] OP_DIV  = 5'd3;
	localparam logic [4:0] OP_MOD  = 5'd4;
	localparam logic [4:0] OP_CMP  = 5'd5;
	localparam logic [4:0] OP_AND  = 5'd6;
	localparam logic [4:0] OP_OR   = 5'd7;
	localparam logic [4:0] OP_NOT  = 5'd8;
	localparam logic [4:0] OP_MOV  = 5'd9;
	localparam logic [4:0] OP_LSL  = 5'd10;
	localparam logic [4:0] OP_LSR  = 5'd11;
	localparam logic [4:0] OP_ASR  = 5'd12;
	localparam logic [4:0] OP_NOP  = 5'd13;
	localparam logic [4:0] OP_LD   = 5'd14;
	localparam logic [4:0] OP_ST   = 5'd15;
	localparam logic [4:0] OP_BEQ  = 5'd16;
	localparam logic [4:0] OP_BGT  = 5'd17;
	localparam logic [4:0] OP_B    = 5'd18;
	localparam logic [4:0] OP_CALL = 5'd19;
	localparam logic [4:0] OP_RET  = 5'd20;

	localparam logic [1:0] MOD_ZEXT = 2'd1;
	localparam logic [1:0] MOD_HIGH = 2'd2;

	localparam logic [3:0] REG_LINK = 4'd15;
	localparam logic [3:0] REG_SP   = 4'd14;
	localparam logic [31:0] SP_RESET = 32'd3000;
	localparam logic [31:0] PC_STEP  = 32'd4;

	// Decoded instruction as it travels from front to back
	typedef struct packed {
		logic [4:0]  op;
		logic        use_imm;
		logic [3:0]  rd;
		logic [3:0]  rs1;
		logic [3:0]  rs2;
		logic [31:0] imm;
		logic [31:0] off;
		logic        zero;
	} rie_item_t;

	// Extend the 16-bit immediate as the modifier says
	function automatic logic [31:0] make_imm(input logic [31:0] w);
		logic [15:0] low;
		logic [1:0]  md;
		low = w[15:0];
		md  = w[17:16];
		if (md == MOD_ZEXT)
			return {16'h0000, low};
		else if (md == MOD_HIGH)
			return {low, 16'h0000};
		else
			return {{16{low[15]}}, low};
	endfunction

endpackage

/* hdl/rie_ram.sv */
// Generic single-port RAM with registered read.
module rie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and read one word per cycle
	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

/* hdl/rie_front.sv */
// Front end: accepts instruction words, decodes them and queues them.
module rie_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [31:0]        instr_word,
	input  logic               clearing,
	output logic               full,
	output logic               q_valid,
	input  logic               q_take,
	output rie_pkg::rie_item_t q_item
);
	rie_pkg::rie_item_t ent_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	rie_pkg::rie_item_t dec;
	logic               do_push;
	logic               do_pop;

	// classify the incoming word
	always_comb begin
		dec.op      = instr_word[31:27];
		dec.use_imm = instr_word[26];
		dec.rd      = instr_word[25:22];
		dec.rs1     = instr_word[21:18];
		dec.rs2     = instr_word[17:14];
		dec.imm     = rie_pkg::make_imm(instr_word);
		dec.off     = {{3{instr_word[26]}}, instr_word[26:0], 2'b00};
		dec.zero    = (instr_word == 32'd0);
	end

	assign full    = (cnt_q == 2'd2) || clearing;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = ent_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	// store decoded beats
	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= dec;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule

/* hdl/rie_back.sv */
// Back end: reads operands, executes, holds architectural state and the result.
module rie_back #(
	parameter int DATA_WORDS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_take,
	input  rie_pkg::rie_item_t q_item,
	output logic               clearing,
	input  logic               pop,
	output logic               empty,
	output logic [31:0]        next_pc,
	output logic               wr_enable,
	output logic [3:0]         wr_index,
	output logic [31:0]        wr_value,
	output logic               eq_flag,
	output logic               gt_flag,
	output logic               mem_fault,
	output logic               halted
);
	localparam int AW = $clog2(DATA_WORDS);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RB    = 3'd2;
	localparam logic [2:0] ST_EXEC  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_LOAD  = 3'd5;

	logic [2:0]         state_q;
	logic [AW-1:0]      clr_q;
	rie_pkg::rie_item_t cur_q;
	logic [31:0]        rf_q [16];
	logic [31:0]        pc_q;
	logic               eqf_q;
	logic               gtf_q;
	logic [31:0]        a_q;
	logic [31:0]        b_q;
	logic [31:0]        rem_q;
	logic [31:0]        quo_q;
	logic [31:0]        dvs_q;
	logic [4:0]         dcnt_q;
	logic               out_valid_q;

	logic [31:0] sum_ab;
	logic [31:0] addr;
	logic        addr_bad;
	logic [AW-1:0] widx;
	logic [31:0] target;
	logic [32:0] trial;
	logic        qbit;
	logic [31:0] rem_n;
	logic [31:0] quo_n;

	logic        e_go;
	logic [31:0] e_npc;
	logic        e_wr;
	logic [3:0]  e_idx;
	logic [31:0] e_val;
	logic        e_eq;
	logic        e_gt;
	logic        e_fault;
	logic        e_halt;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	rie_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign clearing = (state_q == ST_CLEAR);
	assign q_take   = (state_q == ST_IDLE) && q_valid && !out_valid_q;
	assign empty    = !out_valid_q;

	// address and branch arithmetic
	assign sum_ab   = a_q + b_q;
	assign addr     = a_q + cur_q.imm;
	assign addr_bad = (addr[31:2] >= 30'(DATA_WORDS));
	assign widx     = addr[AW+1:2];
	assign target   = pc_q + cur_q.off;

	// one restoring divide step
	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign qbit  = !trial[32];
	assign rem_n = qbit ? trial[31:0] : {rem_q[30:0], quo_q[31]};
	assign quo_n = {quo_q[30:0], qbit};

	// memory port: clear sweep, store, or load read
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = widx;
		ram_wdata = b_q;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q;
			ram_wdata = 32'd0;
		end else if (state_q == ST_EXEC && cur_q.op == rie_pkg::OP_ST && !cur_q.zero
				&& !addr_bad) begin
			ram_we = 1'b1;
		end
	end

	// work out the result of the current instruction
	always_comb begin
		e_go    = 1'b0;
		e_npc   = pc_q + rie_pkg::PC_STEP;
		e_wr    = 1'b0;
		e_idx   = cur_q.rd;
		e_val   = 32'd0;
		e_eq    = eqf_q;
		e_gt    = gtf_q;
		e_fault = 1'b0;
		e_halt  = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				e_go = 1'b1;
				if (cur_q.zero) begin
					e_halt = 1'b1;
					e_npc  = pc_q;
				end else begin
					unique case (cur_q.op)
						rie_pkg::OP_ADD: begin e_val = sum_ab; e_wr = 1'b1; end
						rie_pkg::OP_SUB: begin e_val = a_q - b_q; e_wr = 1'b1; end
						rie_pkg::OP_MUL: begin e_val = a_q * b_q; e_wr = 1'b1; end
						rie_pkg::OP_DIV: begin
							e_val = 32'hFFFF_FFFF;
							e_wr  = 1'b1;
							e_go  = (b_q == 32'd0);
						end
						rie_pkg::OP_MOD: begin
							e_val = a_q;
							e_wr  = 1'b1;
							e_go  = (b_q == 32'd0);
						end
						rie_pkg::OP_CMP: begin
							e_eq = (a_q == b_q);
							e_gt = ($signed(a_q) > $signed(b_q));
						end
						rie_pkg::OP_AND: begin e_val = a_q & b_q; e_wr = 1'b1; end
						rie_pkg::OP_OR:  begin e_val = a_q | b_q; e_wr = 1'b1; end
						rie_pkg::OP_NOT: begin e_val = ~b_q; e_wr = 1'b1; end
						rie_pkg::OP_MOV: begin e_val = b_q; e_wr = 1'b1; end
						rie_pkg::OP_LSL: begin
							e_val = (b_q[31:5] != 27'd0) ? 32'd0 : (a_q << b_q[4:0]);
							e_wr  = 1'b1;
						end
						rie_pkg::OP_LSR: begin
							e_val = (b_q[31:5] != 27'd0) ? 32'd0 : (a_q >> b_q[4:0]);
							e_wr  = 1'b1;
						end
						rie_pkg::OP_ASR: begin
							e_val = (b_q[31:5] != 27'd0) ? {32{a_q[31]}}
								: 32'($signed(a_q) >>> b_q[4:0]);
							e_wr  = 1'b1;
						end
						rie_pkg::OP_LD: begin
							e_fault = addr_bad;
							e_go    = addr_bad;
						end
						rie_pkg::OP_ST: e_fault = addr_bad;
						rie_pkg::OP_BEQ: if (eqf_q) e_npc = target;
						rie_pkg::OP_BGT: if (gtf_q) e_npc = target;
						rie_pkg::OP_B:   e_npc = target;
						rie_pkg::OP_CALL: begin
							e_val = pc_q + rie_pkg::PC_STEP;
							e_idx = rie_pkg::REG_LINK;
							e_wr  = 1'b1;
							e_npc = target;
						end
						rie_pkg::OP_RET: e_npc = rf_q[rie_pkg::REG_LINK];
						default: ;
					endcase
				end
			end
			ST_DIV: begin
				e_go  = (dcnt_q == 5'd0);
				e_wr  = 1'b1;
				e_val = (cur_q.op == rie_pkg::OP_DIV) ? quo_n : rem_n;
			end
			ST_LOAD: begin
				e_go  = 1'b1;
				e_wr  = 1'b1;
				e_val = ram_rdata;
			end
			default: ;
		endcase
	end

	// hold operands and the divider datapath; a store always takes rd as its data
	always_ff @(posedge clk) begin
		if (q_take) begin
			cur_q <= q_item;
			a_q   <= rf_q[q_item.rs1];
		end
		if (state_q == ST_RB)
			b_q <= (cur_q.op == rie_pkg::OP_ST) ? rf_q[cur_q.rd]
				: (cur_q.use_imm ? cur_q.imm : rf_q[cur_q.rs2]);
		if (state_q == ST_EXEC) begin
			rem_q <= 32'd0;
			quo_q <= a_q;
			dvs_q <= b_q;
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
		if (e_go) begin
			next_pc   <= e_npc;
			wr_enable <= e_wr;
			wr_index  <= e_wr ? e_idx : 4'd0;
			wr_value  <= e_wr ? e_val : 32'd0;
			eq_flag   <= e_eq;
			gt_flag   <= e_gt;
			mem_fault <= e_fault;
			halted    <= e_halt;
		end
	end

	// sequence, architectural state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			dcnt_q      <= 5'd0;
			out_valid_q <= 1'b0;
			pc_q        <= 32'd0;
			eqf_q       <= 1'b0;
			gtf_q       <= 1'b0;
			for (int i = 0; i < 16; i++)
				rf_q[i] <= (4'(i) == rie_pkg::REG_SP) ? rie_pkg::SP_RESET : 32'd0;
		end else begin
			if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			if (e_go) begin
				out_valid_q <= 1'b1;
				pc_q        <= e_npc;
				eqf_q       <= e_eq;
				gtf_q       <= e_gt;
				if (e_wr)
					rf_q[e_idx] <= e_val;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DATA_WORDS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: if (q_take) state_q <= ST_RB;
				ST_RB:   state_q <= ST_EXEC;
				ST_EXEC: begin
					dcnt_q <= 5'd31;
					if (e_go)
						state_q <= ST_IDLE;
					else if (cur_q.op == rie_pkg::OP_LD)
						state_q <= ST_LOAD;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q - 5'd1;
					if (e_go)
						state_q <= ST_IDLE;
				end
				ST_LOAD: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* hdl/risc_instruction_execute_unit.sv */
// Top level of the instruction execute unit.
// Each accepted beat goes through operand read and execute, and its result is registered;
// a load adds a memory read, and a divide or modulo by a nonzero value adds a divide state
// that produces one quotient bit a cycle.
// An instruction goes through take, operand read, execute and pop; the back end takes the
// next beat only once the result beat has been popped.
// Reset: asynchronous; afterwards the data memory is swept to zero with full held high.
module risc_instruction_execute_unit #(
	parameter int DATA_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] instr_word,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] next_pc,
	output logic        wr_enable,
	output logic [3:0]  wr_index,
	output logic [31:0] wr_value,
	output logic        eq_flag,
	output logic        gt_flag,
	output logic        mem_fault,
	output logic        halted
);
	logic               q_valid;
	logic               q_take;
	logic               clearing;
	rie_pkg::rie_item_t q_item;

	rie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.instr_word (instr_word),
		.clearing   (clearing),
		.full       (full),
		.q_valid    (q_valid),
		.q_take     (q_take),
		.q_item     (q_item)
	);

	rie_back #(.DATA_WORDS(DATA_WORDS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_item    (q_item),
		.clearing  (clearing),
		.pop       (pop),
		.empty     (empty),
		.next_pc   (next_pc),
		.wr_enable (wr_enable),
		.wr_index  (wr_index),
		.wr_value  (wr_value),
		.eq_flag   (eq_flag),
		.gt_flag   (gt_flag),
		.mem_fault (mem_fault),
		.halted    (halted)
	);
endmodule

/* hdl/rie_checker.sv */
// Port checker for the instruction execute unit, bound to the top level.
module rie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [31:0] next_pc,
	input logic        wr_enable,
	input logic [3:0]  wr_index,
	input logic [31:0] wr_value,
	input logic        mem_fault,
	input logic        halted
);
	// a waiting result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(next_pc) && $stable(wr_value)))
		else $error("result changed while stalled");

	// a halt writes nothing and faults nothing
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && halted) |-> (!wr_enable && !mem_fault))
		else $error("halt with side effects");

	// no write means zero index and value
	a_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !wr_enable) |-> (wr_index == 4'd0 && wr_value == 32'd0))
		else $error("stale write fields");

	// a faulting access writes no register
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && mem_fault) |-> !wr_enable)
		else $error("fault with register write");
endmodule

bind risc_instruction_execute_unit rie_checker u_rie_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.next_pc   (next_pc),
	.wr_enable (wr_enable),
	.wr_index  (wr_index),
	.wr_value  (wr_value),
	.mem_fault (mem_fault),
	.halted    (halted)
);
